// ----- hdl/lprl_pkg.sv -----
`default_nettype none

package lprl_pkg;

    // fixed field widths
    localparam int ADDR_W = 32;
    localparam int IDX_W  = 4;
    localparam int PORT_W = 2;

    // table depth default and the number of slots a 4-bit index can reach
    localparam int ROUTES_DEF = 16;
    localparam int SLOT_LIMIT = 1 << IDX_W;

    // action codes
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] dest;
        logic [ADDR_W-1:0] mask;
        logic [ADDR_W-1:0] gateway;
        logic [PORT_W-1:0] port;
    } t_entry;

endpackage

`default_nettype wire

// ----- hdl/lprl_if.sv -----
`default_nettype none

interface lprl_req_if
    import lprl_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [IDX_W-1:0]  entry_index;
    logic [ADDR_W-1:0] entry_dest;
    logic [ADDR_W-1:0] entry_mask;
    logic [ADDR_W-1:0] entry_gateway;
    logic [PORT_W-1:0] entry_port;
    logic              entry_enable;
    logic [ADDR_W-1:0] lookup_addr;

    modport source (
        output valid, action, entry_index, entry_dest, entry_mask,
               entry_gateway, entry_port, entry_enable, lookup_addr,
        input  ready
    );
    modport sink (
        input  valid, action, entry_index, entry_dest, entry_mask,
               entry_gateway, entry_port, entry_enable, lookup_addr,
        output ready
    );
endinterface

interface lprl_rsp_if
    import lprl_pkg::*;
    ();
    logic              valid;
    logic              ready;
    logic              found;
    logic [IDX_W-1:0]  hit_index;
    logic [PORT_W-1:0] out_port;
    logic [ADDR_W-1:0] next_hop;

    modport source (
        output valid, found, hit_index, out_port, next_hop,
        input  ready
    );
    modport sink (
        input  valid, found, hit_index, out_port, next_hop,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/longest_prefix_route_lookup.sv -----
// longest-prefix route lookup over a small ipv4 route table
//
// channels: i_req carries one item per valid/ready handshake, either a route
// write (action 0) or an address lookup (action 1). o_rsp returns exactly one
// item per request: found, hit_index, out_port and next_hop. writes answer
// with an all-zero item.
//
// sequence: a write is stored at the accepting edge, then its item is loaded
// into the output register from the done state. a lookup reads the route
// memory one entry per cycle over all min(ROUTES,16) slots, then passes the
// drain state and loads its result from the done state. the route memory has
// a single read port. one item is in work at a time; a new request is taken
// only in the idle state.
//
// reset: i_rst_n is synchronous, active low. it clears all valid bits, the
// state machine and the output valid flag; the route memory itself is not
// cleared, entries are only trusted once their valid bit is set.
//
// stall: o_rsp holds its item until taken. a new request is accepted while
// that item waits; its result is held internally until the output frees up.
`default_nettype none

module longest_prefix_route_lookup
    import lprl_pkg::*;
#(
    parameter int ROUTES = ROUTES_DEF
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    lprl_req_if.sink   i_req,
    lprl_rsp_if.source o_rsp
);

    // only slots reachable by the 4-bit write index are stored
    localparam int SLOTS = (ROUTES < SLOT_LIMIT) ? ROUTES : SLOT_LIMIT;
    localparam int IW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

    // route memory, one synchronous read port, one write port
    t_entry r_mem [SLOTS];
    logic   [SLOTS-1:0] r_valid;

    t_state r_state, n_state;

    logic              req_acc;
    logic              wr_slot_ok;
    logic [IW-1:0]     wr_addr;

    // scan pipeline
    logic [IW-1:0]     r_rd_addr;
    t_entry            r_rd_data;
    logic              r_rd_valid;
    logic [IW-1:0]     r_rd_idx;
    logic              r_eval_en;
    logic [ADDR_W-1:0] r_addr;

    // best match so far
    logic              r_hit;
    logic [IW-1:0]     r_best_idx;
    logic [ADDR_W-1:0] r_best_mask;
    logic [ADDR_W-1:0] r_best_gw;
    logic [PORT_W-1:0] r_best_port;

    logic              match;
    logic              take;

    // output register
    logic              r_out_valid;
    logic              r_out_found;
    logic [IDX_W-1:0]  r_out_idx;
    logic [PORT_W-1:0] r_out_port;
    logic [ADDR_W-1:0] r_out_hop;
    logic              out_free;
    logic              out_load;

    assign req_acc    = i_req.valid && i_req.ready;
    assign wr_slot_ok = ({1'b0, i_req.entry_index} < (IDX_W + 1)'(SLOTS));
    assign wr_addr    = IW'(i_req.entry_index);
    assign out_free   = !r_out_valid || o_rsp.ready;

    // next state and handshake
    always_comb begin
        n_state     = r_state;
        i_req.ready = 1'b0;
        out_load    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = (i_req.action == ACT_LOOKUP) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN: begin
                if (r_rd_addr == LAST_SLOT) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // memory write port and valid bits
    always_ff @(posedge i_clk) begin
        if (req_acc && i_req.action == ACT_WRITE && wr_slot_ok) begin
            r_mem[wr_addr] <= '{dest:    i_req.entry_dest,
                                mask:    i_req.entry_mask,
                                gateway: i_req.entry_gateway,
                                port:    i_req.entry_port};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (req_acc && i_req.action == ACT_WRITE && wr_slot_ok) begin
            r_valid[wr_addr] <= i_req.entry_enable;
        end
    end

    // memory read port, one entry per cycle while scanning
    always_ff @(posedge i_clk) begin
        r_rd_data  <= r_mem[r_rd_addr];
        r_rd_valid <= r_valid[r_rd_addr];
        r_rd_idx   <= r_rd_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_addr <= '0;
            r_eval_en <= 1'b0;
        end else begin
            r_eval_en <= (r_state == ST_SCAN);
            if (r_state == ST_SCAN) begin
                r_rd_addr <= (r_rd_addr == LAST_SLOT) ? '0 : r_rd_addr + IW'(1);
            end else begin
                r_rd_addr <= '0;
            end
        end
    end

    // compare stage: strictly larger mask wins, so ties keep the lower index
    assign match = r_rd_valid
        && ((r_rd_data.dest & r_rd_data.mask) == (r_addr & r_rd_data.mask));
    assign take  = r_eval_en && match && (!r_hit || (r_best_mask < r_rd_data.mask));

    always_ff @(posedge i_clk) begin
        if (req_acc && i_req.action == ACT_LOOKUP) begin
            r_addr <= i_req.lookup_addr;
        end
        if (take) begin
            r_best_idx  <= r_rd_idx;
            r_best_mask <= r_rd_data.mask;
            r_best_gw   <= r_rd_data.gateway;
            r_best_port <= r_rd_data.port;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (req_acc) begin
            r_hit <= 1'b0;
        end else if (take) begin
            r_hit <= 1'b1;
        end
    end

    // output register, zero payload when nothing was found or on a write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_found <= r_hit;
            r_out_idx   <= r_hit ? IDX_W'(r_best_idx) : '0;
            r_out_port  <= r_hit ? r_best_port : '0;
            r_out_hop   <= !r_hit ? '0 : ((r_best_gw != '0) ? r_best_gw : r_addr);
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.found     = r_out_found;
    assign o_rsp.hit_index = r_out_idx;
    assign o_rsp.out_port  = r_out_port;
    assign o_rsp.next_hop  = r_out_hop;

    // a lookup starts the scan on the next cycle
    a_lookup_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && i_req.action == ACT_LOOKUP) |=> (r_state == ST_SCAN))
        else $error("lookup did not start a scan");

    // the scan ends after the last slot is read
    a_scan_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_rd_addr == LAST_SLOT) |=> (r_state == ST_DRAIN))
        else $error("scan did not end after last slot");

    // a new output item only comes from the done state
    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !$past(r_out_valid)) |-> ($past(r_state) == ST_DONE))
        else $error("output loaded outside done state");

    // a miss reports an all-zero item
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_found)
            |-> (r_out_idx == '0 && r_out_port == '0 && r_out_hop == '0))
        else $error("miss item carries nonzero fields");

endmodule

`default_nettype wire
